// ===== rtl/carvb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the comb/allpass stereo reverb.
// No dependencies; used by the top level.
package carvb_pkg;

	localparam int SampleW    = 16;
	localparam int NumCombs   = 6;
	localparam int NumAps     = 6;
	localparam int NumLines   = NumCombs + NumAps;
	localparam int CombMaxLen = 8192;
	localparam int ApMaxLen   = 1024;
	localparam int PosW       = 13;
	localparam int CombDepth  = NumCombs * CombMaxLen;
	localparam int ApDepth    = NumAps * ApMaxLen;
	localparam int CombAw     = $clog2(CombDepth);
	localparam int ApAw       = $clog2(ApDepth);
	localparam int ApPosW     = $clog2(ApMaxLen);

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [14:0]               gain_t;
	typedef logic [PosW-1:0]           pos_t;
	typedef logic [3:0]                line_t;
	typedef logic [16:0]               coef_t;

	// delay lengths: base length scaled to 44.1 kHz, made odd, next prime
	localparam pos_t LineLen [NumLines] = '{
		13'd2467, 13'd2753, 13'd3217, 13'd3533, 13'd3877, 13'd4127,
		13'd599,  13'd197,  13'd67,   13'd101,  13'd97,   13'd73
	};

	// line numbers with a role of their own in the chain
	localparam line_t LineFirstAp = 4'd6;
	localparam line_t LineLpAfter = 4'd8;
	localparam line_t LineT1      = 4'd9;
	localparam line_t LineWl      = 4'd10;
	localparam line_t LineLast    = 4'd11;

	// config register indexes
	localparam logic [2:0] RegApGain = 3'd6;
	localparam logic [2:0] RegWetMix = 3'd7;

	localparam gain_t       CombGainRst = 15'd29491;
	localparam gain_t       ApGainRst   = 15'd22938;
	localparam logic [15:0] WetMixRst   = 16'd9830;

	localparam coef_t QOne  = 17'd32768;
	localparam coef_t LpOld = 17'd22938;
	localparam coef_t LpNew = 17'd9830;

	function automatic sample_t sat16(input logic signed [19:0] v);
		if (v > 20'sd32767)
			return 16'sh7fff;
		else if (v < -20'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

// ===== rtl/carvb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels of the reverb: sample input and stereo result.
// Standalone; payload widths match carvb_pkg::SampleW.
interface carvb_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_in;
	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface carvb_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic signed [15:0] mono_out;
	modport source (output valid, output left_out, output right_out, output mono_out,
		input ready);
	modport sink (input valid, input left_out, input right_out, input mono_out,
		output ready);
endinterface

// ===== rtl/comb_allpass_stereo_reverb_unit.sv =====
`timescale 1ns / 1ps
// Comb/allpass stereo reverb, top level.
// Depends on carvb_pkg and the channel interfaces in carvb_if.sv.

// One mono Q1.15 sample in, one left/right/mono beat out. Six feedback combs
// are summed, pass three series allpasses, a fixed one-pole lowpass and a
// fourth allpass, and two parallel allpasses make the wet left and right
// signals, mixed with the dry input by wet_mix. All math is Q1.15 with
// round-half-up products and 16-bit saturation. Each sample runs from
// accept to the next possible accept through the accept step in idle, a
// read step and a write-back step per delay line for twelve lines, two
// steps for the lowpass and three for the output mix, all on one shared
// multiply-add-saturate unit. The result sits in an output register; the
// input waits while a previous result is still not taken at the end of the
// mix. Delay memories are not cleared after reset: a per-line wrap flag
// makes entries not yet written read as zero, so the block is ready right
// out of reset. Config writes are taken any cycle but are meant for idle
// periods.
module comb_allpass_stereo_reverb_unit (
	input logic             clk,
	input logic             arst_n,
	carvb_sample_if.sink    smp,
	carvb_result_if.source  res,
	input logic             cfg_we,
	input logic [2:0]       cfg_index,
	input logic [15:0]      cfg_data
);
	import carvb_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_WR    = 4'd2;
	localparam logic [3:0] S_LP0   = 4'd3;
	localparam logic [3:0] S_LP1   = 4'd4;
	localparam logic [3:0] S_DRY   = 4'd5;
	localparam logic [3:0] S_LEFT  = 4'd6;
	localparam logic [3:0] S_RIGHT = 4'd7;

	// config registers
	gain_t       comb_gain_q [NumCombs];
	gain_t       ap_gain_q;
	logic [15:0] wet_mix_q;

	// sequencer and datapath state
	logic [3:0]        state_q;
	line_t             k_q;
	sample_t           x_q;
	logic signed [18:0] acc_q;
	sample_t           w_q;       // value to store, also scratch for lowpass / dry
	sample_t           chain_q;   // running allpass chain value
	sample_t           t1_q;
	sample_t           wl_q;
	sample_t           left_q;
	sample_t           lp_q;
	sample_t           last_q [NumLines];
	pos_t              pos_q [NumLines];
	logic [NumLines-1:0] full_q;  // line has wrapped once
	logic              res_valid_q;
	sample_t           left_out_q, right_out_q, mono_out_q;

	// delay memories
	sample_t comb_mem [CombDepth];
	sample_t ap_mem [ApDepth];
	sample_t comb_rd_q, ap_rd_q;

	logic              is_comb;
	pos_t              pos_cur;
	pos_t              pos_nxt;
	logic              wrap;
	line_t             ap_sel;
	logic [CombAw-1:0] comb_addr;
	logic [ApAw-1:0]   ap_addr;
	sample_t           rd_val;
	sample_t           ap_in;
	coef_t             mix;
	logic              out_free;

	// shared multiply-add-saturate unit: sat(add +/- round(a * c / 2^15))
	sample_t            alu_add;
	sample_t            alu_a;
	coef_t              alu_c;
	logic               alu_sub;
	logic signed [33:0] alu_prod;
	logic signed [33:0] alu_rnd;
	logic signed [18:0] alu_q;
	logic signed [19:0] alu_sum;
	sample_t            alu_res;
	logic signed [16:0] lr_sum;

	assign is_comb   = (k_q < line_t'(NumCombs));
	assign pos_cur   = pos_q[k_q];
	assign wrap      = (pos_cur == LineLen[k_q] - pos_t'(1));
	assign pos_nxt   = wrap ? '0 : pos_cur + pos_t'(1);
	assign ap_sel    = k_q - LineFirstAp;
	assign comb_addr = {k_q[2:0], pos_cur};
	assign ap_addr   = {ap_sel[2:0], pos_cur[ApPosW-1:0]};
	assign rd_val    = full_q[k_q] ? (is_comb ? comb_rd_q : ap_rd_q) : '0;
	assign mix       = (wet_mix_q > QOne[15:0] && wet_mix_q[15]) ? QOne : {1'b0, wet_mix_q};
	assign out_free  = !res_valid_q || res.ready;

	always_comb begin
		if (k_q == LineFirstAp)
			ap_in = sat16(20'(acc_q));
		else if (k_q == LineLast)
			ap_in = t1_q;
		else
			ap_in = chain_q;
	end

	always_comb begin
		alu_add = '0;
		alu_a   = '0;
		alu_c   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_RD: begin
				alu_a = last_q[k_q];
				if (is_comb) begin
					alu_add = x_q;
					alu_c   = {2'b00, comb_gain_q[k_q[2:0]]};
				end else begin
					alu_add = ap_in;
					alu_c   = {2'b00, ap_gain_q};
				end
			end
			S_WR: begin
				alu_add = last_q[k_q];
				alu_a   = w_q;
				alu_c   = {2'b00, ap_gain_q};
				alu_sub = 1'b1;
			end
			S_LP0: begin
				alu_a = chain_q;
				alu_c = LpNew;
			end
			S_LP1: begin
				alu_add = w_q;
				alu_a   = lp_q;
				alu_c   = LpOld;
			end
			S_DRY: begin
				alu_a = x_q;
				alu_c = QOne - mix;
			end
			S_LEFT: begin
				alu_add = w_q;
				alu_a   = wl_q;
				alu_c   = mix;
			end
			S_RIGHT: begin
				alu_add = w_q;
				alu_a   = chain_q;
				alu_c   = mix;
			end
			default: begin
				alu_add = '0;
			end
		endcase
	end

	assign alu_prod = 34'(alu_a) * 34'($signed({1'b0, alu_c}));
	assign alu_rnd  = alu_prod + 34'sd16384;
	assign alu_q    = alu_rnd[33:15];
	assign alu_sum  = alu_sub ? (20'(alu_add) - 20'(alu_q)) : (20'(alu_add) + 20'(alu_q));
	assign alu_res  = sat16(alu_sum);
	assign lr_sum   = 17'(left_q) + 17'(alu_res);

	// delay memories: read in the read step of a line, write in the write-back step
	always_ff @(posedge clk) begin
		if (state_q == S_RD && is_comb)
			comb_rd_q <= comb_mem[comb_addr];
		if (state_q == S_WR && is_comb)
			comb_mem[comb_addr] <= w_q;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD && !is_comb)
			ap_rd_q <= ap_mem[ap_addr];
		if (state_q == S_WR && !is_comb)
			ap_mem[ap_addr] <= w_q;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumCombs; i++)
				comb_gain_q[i] <= CombGainRst;
			ap_gain_q <= ApGainRst;
			wet_mix_q <= WetMixRst;
		end else if (cfg_we) begin
			case (cfg_index)
				RegApGain: ap_gain_q <= cfg_data[14:0];
				RegWetMix: wet_mix_q <= cfg_data;
				default:   comb_gain_q[cfg_index] <= cfg_data[14:0];
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			acc_q       <= '0;
			lp_q        <= '0;
			full_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < NumLines; i++) begin
				last_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			// output register: loaded by the last mix step, else drained
			if (state_q == S_RIGHT && out_free)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (smp.valid) begin
						x_q     <= smp.sample_in;
						acc_q   <= '0;
						k_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					w_q     <= alu_res;
					state_q <= S_WR;
				end
				S_WR: begin
					last_q[k_q] <= rd_val;
					pos_q[k_q]  <= pos_nxt;
					if (wrap)
						full_q[k_q] <= 1'b1;
					if (is_comb) begin
						acc_q <= acc_q + 19'(rd_val);
					end else begin
						chain_q <= alu_res;
						if (k_q == LineT1)
							t1_q <= alu_res;
						if (k_q == LineWl)
							wl_q <= alu_res;
					end
					if (k_q == LineLast) begin
						state_q <= S_DRY;
					end else begin
						k_q     <= k_q + line_t'(1);
						state_q <= (k_q == LineLpAfter) ? S_LP0 : S_RD;
					end
				end
				S_LP0: begin
					w_q     <= alu_res;
					state_q <= S_LP1;
				end
				S_LP1: begin
					lp_q    <= alu_res;
					chain_q <= alu_res;
					state_q <= S_RD;
				end
				S_DRY: begin
					w_q     <= alu_res;
					state_q <= S_LEFT;
				end
				S_LEFT: begin
					left_q  <= alu_res;
					state_q <= S_RIGHT;
				end
				S_RIGHT: begin
					if (out_free) begin
						left_out_q  <= left_q;
						right_out_q <= alu_res;
						mono_out_q  <= lr_sum[16:1];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign smp.ready     = (state_q == S_IDLE);
	assign res.valid     = res_valid_q;
	assign res.left_out  = left_out_q;
	assign res.right_out = right_out_q;
	assign res.mono_out  = mono_out_q;

	// a new beat only comes out of the last mix step
	a_valid_from_mix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == S_RIGHT))
		else $error("result valid without finishing the mix");

	// line index stays inside the twelve lines while a line is processed
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_WR) |-> (k_q <= LineLast))
		else $error("line index out of range");

	// a pending result that is not taken holds the sequencer in the mix step
	a_hold_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RIGHT && res.valid && !res.ready) |=> (state_q == S_RIGHT))
		else $error("pending result overwritten");

endmodule
